FILE: src/rarmc_pkg.sv
// rarmc_pkg: types and codes shared by the rack mode controller
// request and result payload structs, controller state, key and serial codes
// no dependencies
`default_nettype none

package rarmc_pkg;

  localparam logic [4:0] KEY_NONE      = 5'd0;
  localparam logic [4:0] KEY_DIGIT_MAX = 5'd10;
  localparam logic [4:0] KEY_START     = 5'd11;
  localparam logic [4:0] KEY_CONFIRM   = 5'd12;
  localparam logic [4:0] KEY_MODE      = 5'd13;
  localparam logic [4:0] KEY_ACTION    = 5'd14;

  localparam logic [7:0] SER_NONE    = 8'h00;
  localparam logic [7:0] SER_ACTION  = 8'h01;
  localparam logic [7:0] SER_MODE    = 8'h02;
  localparam logic [7:0] SER_START   = 8'h03;
  localparam logic [7:0] SER_CONFIRM = 8'h04;

  localparam logic [7:0] VALUE_MAX = 8'd255;

  typedef struct packed {
    logic [4:0] key_code;
    logic       serial_valid;
    logic [7:0] serial_byte;
    logic       voice_select;
    logic       voice_mode;
    logic       voice_action;
    logic       rain_pin;
    logic [7:0] light_level;
  } item_t;

  typedef struct packed {
    logic       mode_out;
    logic       drive_withdraw;
    logic [7:0] threshold_out;
    logic       store_write;
    logic [7:0] press_total;
    logic       voice_active;
    logic       is_night;
    logic       entry_open;
  } result_t;

  typedef struct packed {
    logic       manual_mode;
    logic       withdraw_action;
    logic       entry_enabled;
    logic [1:0] digit_count;
    logic [7:0] entry_value;
    logic [7:0] stored_threshold;
    logic [7:0] press_counter;
    logic [2:0] pending_serial_cmd;
  } state_t;

endpackage

`default_nettype wire

FILE: src/rain_aware_rack_mode_controller_unit.sv
// rain_aware_rack_mode_controller_unit: top level of the rack mode controller
// Usage:
//   in channel  : in_valid_i / in_stall_o, payload in_data_i (item_t), one control
//                 pass per request
//   out channel : out_valid_o / out_stall_i, payload out_data_o (result_t), one
//                 result per request, in request order
//   a request lands in an input register, the pass logic runs between it and the
//   result register, and the controller state updates as the result is written
//   throughput: one request per cycle while the receiver does not stall, set by the single state register update
//   when the receiver stalls, the result register holds and the input register
//   still takes one more request; in_stall_o rises only when both are full
//   reset: mode auto, action extend, entry closed, threshold and press count
//   zero, no pending serial command, both registers empty
// depends on rarmc_pkg and rarmc_core
`default_nettype none

module rain_aware_rack_mode_controller_unit import rarmc_pkg::*; #(
  parameter int unsigned MaxDigits = 2
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  item_t   in_data_i,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output result_t out_data_o
);

  logic    s1_valid_q;
  item_t   s1_item_q;
  logic    out_valid_q;
  result_t out_data_q;
  result_t pass_res;
  logic    advance;

  assign advance    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !advance;

  rarmc_core #(
    .MaxDigits(MaxDigits)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(advance),
    .item_i  (s1_item_q),
    .result_o(pass_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        s1_valid_q <= 1'b1;
      end else if (advance) begin
        s1_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      s1_item_q <= in_data_i;
    end
    if (advance) begin
      out_data_q <= pass_res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_advance_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_o)
    else $error("result lost after advance");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_q && out_stall_i))
    else $error("input stalled with room free");

endmodule

`default_nettype wire

FILE: src/rarmc_pass.sv
// rarmc_pass: combinational logic of one control pass
// maps the current controller state and one request to next state and result
// depends on rarmc_pkg
`default_nettype none

module rarmc_pass import rarmc_pkg::*; #(
  parameter int unsigned MaxDigits = 2
) (
  input  state_t  state_i,
  input  item_t   item_i,
  output state_t  state_o,
  output result_t result_o
);

  localparam logic [1:0] MaxDigitsW = MaxDigits[1:0];

  logic [3:0]  digit;
  logic [11:0] acc;
  logic [7:0]  acc_sat;
  logic        serial_hit;
  logic        ser_store;
  logic        key_store;

  assign digit = (item_i.key_code == KEY_DIGIT_MAX) ? 4'd0 : item_i.key_code[3:0];
  assign acc = ({4'b0, state_i.entry_value} << 3) + ({4'b0, state_i.entry_value} << 1)
             + {8'b0, digit};
  assign acc_sat = (acc > {4'b0, VALUE_MAX}) ? VALUE_MAX : acc[7:0];
  assign serial_hit = item_i.serial_valid && (item_i.serial_byte >= SER_ACTION)
                    && (item_i.serial_byte <= SER_CONFIRM);

  always_comb begin
    state_t st;
    st        = state_i;
    key_store = 1'b0;
    ser_store = 1'b0;

    if (serial_hit) begin
      st.pending_serial_cmd = item_i.serial_byte[2:0];
    end

    if (item_i.key_code != KEY_NONE) begin
      st.press_counter = state_i.press_counter + 8'd1;
      if (item_i.key_code <= KEY_DIGIT_MAX) begin
        if (state_i.entry_enabled && (state_i.digit_count < MaxDigitsW)) begin
          st.entry_value = acc_sat;
          st.digit_count = state_i.digit_count + 2'd1;
        end
      end else if (item_i.key_code == KEY_START) begin
        st.entry_enabled = 1'b1;
        st.digit_count   = 2'd0;
        st.entry_value   = 8'd0;
      end else if (item_i.key_code == KEY_CONFIRM) begin
        st.stored_threshold = st.entry_value;
        st.entry_enabled    = 1'b0;
        st.digit_count      = MaxDigitsW;
        key_store           = 1'b1;
      end else if (item_i.key_code == KEY_MODE) begin
        if (!item_i.voice_select) begin
          st.manual_mode = ~st.manual_mode;
        end
      end else if (item_i.key_code == KEY_ACTION) begin
        st.manual_mode     = 1'b1;
        st.withdraw_action = ~st.withdraw_action;
      end
    end

    if (item_i.voice_select) begin
      st.manual_mode     = item_i.voice_mode;
      st.withdraw_action = item_i.voice_action;
    end else begin
      case ({5'b0, st.pending_serial_cmd})
        SER_ACTION: begin
          st.manual_mode     = 1'b1;
          st.withdraw_action = ~st.withdraw_action;
        end
        SER_MODE: begin
          st.manual_mode = ~st.manual_mode;
        end
        SER_START: begin
          st.entry_enabled = 1'b1;
          st.digit_count   = 2'd0;
          st.entry_value   = 8'd0;
        end
        SER_CONFIRM: begin
          st.stored_threshold = st.entry_value;
          st.entry_enabled    = 1'b0;
          st.digit_count      = MaxDigitsW;
          ser_store           = 1'b1;
        end
        default: begin
        end
      endcase
      st.pending_serial_cmd = SER_NONE[2:0];
    end

    // auto rule, then rain forces withdraw
    if (!st.manual_mode) begin
      st.withdraw_action = !((item_i.light_level > st.stored_threshold) && item_i.rain_pin);
    end
    if (!item_i.rain_pin) begin
      st.withdraw_action = 1'b1;
    end

    state_o                 = st;
    result_o.mode_out       = st.manual_mode;
    result_o.drive_withdraw = st.withdraw_action;
    result_o.threshold_out  = st.stored_threshold;
    result_o.store_write    = key_store || ser_store;
    result_o.press_total    = st.press_counter;
    result_o.voice_active   = item_i.voice_select;
    result_o.is_night       = item_i.light_level < st.stored_threshold;
    result_o.entry_open     = st.entry_enabled;
  end

endmodule

`default_nettype wire

FILE: src/rarmc_core.sv
// rarmc_core: controller state register around the pass logic
// state advances once for each request that moves to the result register
// depends on rarmc_pkg and rarmc_pass
`default_nettype none

module rarmc_core import rarmc_pkg::*; #(
  parameter int unsigned MaxDigits = 2
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    accept_i,
  input  item_t   item_i,
  output result_t result_o
);

  state_t state_q;
  state_t state_d;

  rarmc_pass #(
    .MaxDigits(MaxDigits)
  ) u_pass (
    .state_i (state_q),
    .item_i  (item_i),
    .state_o (state_d),
    .result_o(result_o)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (accept_i) begin
      state_q <= state_d;
    end
  end

  a_press_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i |=> state_q.press_counter == $past(state_q.press_counter)
                 + {7'b0, $past(item_i.key_code) != KEY_NONE})
    else $error("press counter step wrong");

  a_threshold_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && !result_o.store_write) |=>
      state_q.stored_threshold == $past(state_q.stored_threshold))
    else $error("threshold changed without confirm");

endmodule

`default_nettype wire

FILE: bench/rain_aware_rack_mode_controller_unit_tb.sv
// rain_aware_rack_mode_controller_unit_tb: self-checking bench for the rack mode controller
// drives directed and random control passes with idle and stall bursts and
// predicts each result in-bench; depends on rarmc_pkg and the controller RTL

module rain_aware_rack_mode_controller_unit_tb;
  import rarmc_pkg::*;

  localparam int unsigned MAX_DIGITS  = 2;
  localparam int unsigned RANDOM_PASSES = 1000;
  localparam int unsigned TAIL_PASSES = 150;
  localparam int unsigned HOLD_AFTER  = 300;
  localparam int unsigned HOLD_CYCLES = 64;
  localparam int unsigned STUCK_LIMIT = 2000;

  logic    clk = 1'b0;
  logic    rst_n = 1'b0;
  logic    in_valid = 1'b0;
  logic    in_stall_o;
  item_t   in_data = '0;
  logic    out_valid_o;
  logic    out_stall = 1'b0;
  result_t out_data_o;

  rain_aware_rack_mode_controller_unit #(.MaxDigits(MAX_DIGITS)) DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_data_o  (out_data_o)
  );

  initial forever #6 clk = ~clk;

  item_t   pending_passes[$];
  result_t expected_results[$];

  // controller state as predicted by the bench
  logic       manual = 1'b0;
  logic       withdraw = 1'b0;
  logic       entry_on = 1'b0;
  logic [1:0] digits = 2'd0;
  logic [7:0] entry_val = 8'd0;
  logic [7:0] threshold = 8'd0;
  logic [7:0] presses = 8'd0;
  logic [7:0] serial_cmd = SER_NONE;

  int unsigned errors = 0;
  int unsigned results_seen = 0;
  int unsigned stores = 0;
  int unsigned rain_passes = 0;
  int unsigned voice_passes = 0;

  logic        quiet = 1'b0;
  logic        hold_on = 1'b0;
  bit          hold_done = 1'b0;
  int unsigned gap_cnt = 0;
  int unsigned stall_cnt = 0;
  int unsigned hold_cnt = 0;

  function automatic void open_entry();
    entry_on = 1'b1;
    digits = 2'd0;
    entry_val = 8'd0;
  endfunction

  function automatic void close_entry();
    threshold = entry_val;
    entry_on = 1'b0;
    digits = 2'(MAX_DIGITS);
  endfunction

  function automatic void flip_action();
    manual = 1'b1;
    withdraw = ~withdraw;
  endfunction

  function automatic result_t control_pass(input item_t it);
    result_t     res;
    logic        store;
    int unsigned acc;
    store = 1'b0;
    res = '0;
    if (it.serial_valid && it.serial_byte >= SER_ACTION && it.serial_byte <= SER_CONFIRM)
      serial_cmd = it.serial_byte;
    if (it.key_code != KEY_NONE) begin
      presses = presses + 8'd1;
      if (it.key_code <= KEY_DIGIT_MAX) begin
        if (entry_on && digits < MAX_DIGITS) begin
          acc = entry_val * 10 + it.key_code % 10;
          entry_val = (acc > VALUE_MAX) ? VALUE_MAX : acc[7:0];
          digits = digits + 2'd1;
        end
      end else if (it.key_code == KEY_START) begin
        open_entry();
      end else if (it.key_code == KEY_CONFIRM) begin
        close_entry();
        store = 1'b1;
      end else if (it.key_code == KEY_MODE) begin
        if (!it.voice_select) manual = ~manual;
      end else if (it.key_code == KEY_ACTION) begin
        flip_action();
      end
    end
    if (it.voice_select) begin
      manual = it.voice_mode;
      withdraw = it.voice_action;
    end else begin
      case (serial_cmd)
        SER_ACTION: flip_action();
        SER_MODE: manual = ~manual;
        SER_START: open_entry();
        SER_CONFIRM: begin
          close_entry();
          store = 1'b1;
        end
        default: ;
      endcase
      serial_cmd = SER_NONE;
    end
    if (!manual) withdraw = !(it.light_level > threshold && it.rain_pin);
    if (!it.rain_pin) withdraw = 1'b1;
    stores += store;
    rain_passes += !it.rain_pin;
    voice_passes += it.voice_select;
    res.mode_out = manual;
    res.drive_withdraw = withdraw;
    res.threshold_out = threshold;
    res.store_write = store;
    res.press_total = presses;
    res.voice_active = it.voice_select;
    res.is_night = it.light_level < threshold;
    res.entry_open = entry_on;
    return res;
  endfunction

  function automatic item_t make_pass(input logic [4:0] key, input logic sv,
                                      input logic [7:0] sb, input logic vsel,
                                      input logic vm, input logic va, input logic dry,
                                      input logic [7:0] light);
    item_t it;
    it.key_code = key;
    it.serial_valid = sv;
    it.serial_byte = sb;
    it.voice_select = vsel;
    it.voice_mode = vm;
    it.voice_action = va;
    it.rain_pin = dry;
    it.light_level = light;
    return it;
  endfunction

  function automatic item_t pass_with(input logic [4:0] key);
    item_t it;
    it.key_code = key;
    it.serial_valid = ($urandom_range(0, 7) == 0);
    it.serial_byte = $urandom_range(0, 1) ? 8'($urandom_range(1, 4)) : 8'($urandom_range(0, 255));
    it.voice_select = ($urandom_range(0, 7) == 0);
    it.voice_mode = 1'($urandom_range(0, 1));
    it.voice_action = 1'($urandom_range(0, 1));
    it.rain_pin = ($urandom_range(0, 7) != 0);
    it.light_level = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                 : 8'($urandom_range(0, 110));
    return it;
  endfunction

  function automatic item_t serial_pass(input logic [7:0] sb);
    item_t it;
    it = pass_with(KEY_NONE);
    it.serial_valid = 1'b1;
    it.serial_byte = sb;
    it.voice_select = ($urandom_range(0, 5) == 0);
    return it;
  endfunction

  function automatic logic [4:0] control_key();
    case ($urandom_range(0, 7))
      0: return KEY_NONE;
      1, 2: return 5'($urandom_range(1, 10));
      3: return KEY_START;
      4: return KEY_CONFIRM;
      5: return KEY_MODE;
      6: return KEY_ACTION;
      default: return 5'($urandom_range(15, 31));
    endcase
  endfunction

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
    end
  endtask

  // request driver
  always @(posedge clk or negedge rst_n) begin : feed
    item_t next_data;
    logic  next_valid;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data <= '0;
      quiet <= 1'b0;
    end else begin
      next_valid = in_valid;
      next_data = in_data;
      if (in_valid && !in_stall_o) begin
        expected_results.push_back(control_pass(in_data));
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (gap_cnt != 0) begin
          gap_cnt--;
        end else if (pending_passes.size() != 0) begin
          if (!quiet && !hold_on && $urandom_range(0, 15) == 0) begin
            gap_cnt = $urandom_range(0, 14);
          end else begin
            next_data = pending_passes.pop_front();
            next_valid = 1'b1;
          end
        end
      end
      in_valid <= next_valid;
      in_data <= next_data;
      quiet <= pending_passes.size() < TAIL_PASSES || pending_passes.size() % 300 < 60;
    end
  end

  // result monitor and receiver stall
  always @(posedge clk or negedge rst_n) begin : drain
    result_t want;
    logic    next_stall;
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_on <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: result expected none got %h", $time, out_data_o);
        end else begin
          want = expected_results.pop_front();
          check_field("mode_out", want.mode_out, out_data_o.mode_out);
          check_field("drive_withdraw", want.drive_withdraw, out_data_o.drive_withdraw);
          check_field("threshold_out", want.threshold_out, out_data_o.threshold_out);
          check_field("store_write", want.store_write, out_data_o.store_write);
          check_field("press_total", want.press_total, out_data_o.press_total);
          check_field("voice_active", want.voice_active, out_data_o.voice_active);
          check_field("is_night", want.is_night, out_data_o.is_night);
          check_field("entry_open", want.entry_open, out_data_o.entry_open);
        end
      end
      next_stall = 1'b0;
      if (hold_cnt != 0) begin
        hold_cnt--;
        next_stall = 1'b1;
      end else if (!hold_done && results_seen >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_cnt = HOLD_CYCLES - 1;
        next_stall = 1'b1;
      end else if (stall_cnt != 0) begin
        stall_cnt--;
        next_stall = 1'b1;
      end else if (!quiet && $urandom_range(0, 15) == 0) begin
        stall_cnt = $urandom_range(0, 14);
        next_stall = 1'b1;
      end
      out_stall <= next_stall;
      hold_on <= (hold_cnt != 0);
    end
  end

  initial begin : watchdog
    int unsigned stuck;
    stuck = 0;
    while (stuck < STUCK_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall)) stuck = 0;
      else stuck++;
    end
    $display("%0t: timeout, nothing moved for %0d cycles", $time, STUCK_LIMIT);
    $display("rain_aware_rack_mode_controller_unit_tb NOT OK");
    $finish;
  end

  initial begin : stimulus
    int unsigned pick;
    int unsigned target;
    // directed passes
    pending_passes.push_back(make_pass(KEY_NONE, 1'b0, SER_NONE, 1'b0, 1'b0, 1'b0, 1'b1, 8'd0));
    pending_passes.push_back(make_pass(KEY_NONE, 1'b0, SER_NONE, 1'b0, 1'b0, 1'b0, 1'b1, 8'd255));
    pending_passes.push_back(make_pass(KEY_NONE, 1'b0, SER_NONE, 1'b0, 1'b0, 1'b0, 1'b0, 8'd255));
    pending_passes.push_back(make_pass(KEY_START, 1'b0, SER_NONE, 1'b0, 1'b0, 1'b0, 1'b1, 8'd50));
    pending_passes.push_back(make_pass(5'd1, 1'b0, SER_NONE, 1'b0, 1'b0, 1'b0, 1'b1, 8'd50));
    pending_passes.push_back(make_pass(5'd2, 1'b0, SER_NONE, 1'b0, 1'b0, 1'b0, 1'b1, 8'd50));
    pending_passes.push_back(make_pass(5'd3, 1'b0, SER_NONE, 1'b0, 1'b0, 1'b0, 1'b1, 8'd50));
    pending_passes.push_back(make_pass(KEY_CONFIRM, 1'b0, SER_NONE, 1'b0, 1'b0, 1'b0, 1'b1, 8'd50));
    pending_passes.push_back(make_pass(KEY_NONE, 1'b0, SER_NONE, 1'b0, 1'b0, 1'b0, 1'b1, 8'd12));
    pending_passes.push_back(make_pass(KEY_NONE, 1'b0, SER_NONE, 1'b0, 1'b0, 1'b0, 1'b1, 8'd11));
    pending_passes.push_back(make_pass(KEY_NONE, 1'b0, SER_NONE, 1'b0, 1'b0, 1'b0, 1'b1, 8'd13));
    pending_passes.push_back(make_pass(KEY_START, 1'b0, SER_NONE, 1'b0, 1'b0, 1'b0, 1'b1, 8'd7));
    pending_passes.push_back(make_pass(KEY_DIGIT_MAX, 1'b0, SER_NONE, 1'b0, 1'b0, 1'b0, 1'b1, 8'd7));
    pending_passes.push_back(make_pass(KEY_CONFIRM, 1'b0, SER_NONE, 1'b0, 1'b0, 1'b0, 1'b1, 8'd7));
    pending_passes.push_back(make_pass(5'd5, 1'b0, SER_NONE, 1'b0, 1'b0, 1'b0, 1'b1, 8'd7));
    pending_passes.push_back(make_pass(KEY_CONFIRM, 1'b1, 8'hFF, 1'b0, 1'b0, 1'b0, 1'b1, 8'd7));
    pending_passes.push_back(make_pass(KEY_MODE, 1'b0, SER_NONE, 1'b0, 1'b0, 1'b0, 1'b1, 8'd7));
    pending_passes.push_back(make_pass(KEY_ACTION, 1'b0, SER_NONE, 1'b0, 1'b0, 1'b0, 1'b1, 8'd7));
    pending_passes.push_back(make_pass(KEY_MODE, 1'b0, SER_NONE, 1'b1, 1'b0, 1'b1, 1'b1, 8'd7));
    pending_passes.push_back(make_pass(KEY_ACTION, 1'b0, SER_NONE, 1'b1, 1'b1, 1'b0, 1'b1, 8'd7));
    pending_passes.push_back(make_pass(KEY_NONE, 1'b1, SER_CONFIRM, 1'b1, 1'b0, 1'b0, 1'b1, 8'd7));
    pending_passes.push_back(make_pass(KEY_NONE, 1'b0, SER_START, 1'b0, 1'b0, 1'b0, 1'b1, 8'd7));
    pending_passes.push_back(make_pass(KEY_NONE, 1'b1, SER_ACTION, 1'b0, 1'b0, 1'b0, 1'b1, 8'd7));
    pending_passes.push_back(make_pass(KEY_NONE, 1'b1, SER_MODE, 1'b0, 1'b0, 1'b0, 1'b1, 8'd7));
    pending_passes.push_back(make_pass(KEY_NONE, 1'b1, SER_START, 1'b0, 1'b0, 1'b0, 1'b1, 8'd7));
    pending_passes.push_back(make_pass(5'd31, 1'b1, 8'hAA, 1'b1, 1'b1, 1'b1, 1'b0, 8'h55));
    pending_passes.push_back(make_pass(5'd15, 1'b1, 8'h55, 1'b0, 1'b0, 1'b0, 1'b1, 8'hAA));
    // random passes, mostly complete threshold entries
    target = pending_passes.size() + RANDOM_PASSES;
    while (pending_passes.size() < target) begin
      pick = $urandom_range(0, 9);
      if (pick < 5) begin
        if ($urandom_range(0, 1)) pending_passes.push_back(pass_with(KEY_START));
        else pending_passes.push_back(serial_pass(SER_START));
        repeat ($urandom_range(0, 3))
          pending_passes.push_back(pass_with(5'($urandom_range(1, 10))));
        if ($urandom_range(0, 1)) pending_passes.push_back(pass_with(KEY_CONFIRM));
        else pending_passes.push_back(serial_pass(SER_CONFIRM));
      end else if (pick < 8) begin
        pending_passes.push_back(pass_with(control_key()));
      end else begin
        pending_passes.push_back(item_t'($urandom));
      end
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    while (pending_passes.size() != 0 || in_valid || expected_results.size() != 0)
      @(negedge clk);
    repeat (8) @(negedge clk);
    if (expected_results.size() != 0) begin
      errors += expected_results.size();
      $display("%0t: %0d results expected got none", $time, expected_results.size());
    end
    $display("%0d control passes checked, %0d threshold stores, %0d in rain, %0d under voice",
             results_seen, stores, rain_passes, voice_passes);
    if (errors == 0) begin
      $display("rain_aware_rack_mode_controller_unit_tb OK");
    end else begin
      $display("rain_aware_rack_mode_controller_unit_tb NOT OK");
    end
    $finish;
  end

endmodule

FILE: files.f
src/rarmc_pkg.sv
src/rarmc_pass.sv
src/rarmc_core.sv
src/rain_aware_rack_mode_controller_unit.sv
bench/rain_aware_rack_mode_controller_unit_tb.sv
